### design/l64sc_pkg.sv
// Shared codes, register map and decoded-item types for the latched 64-bit counter.
`default_nettype none

package l64sc_pkg;

  // Counter halves and bus word width
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned COUNT_W = 2 * HALF_W;

  // Item kinds
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // Fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_LOAD  = 2'd1;
  localparam logic [1:0] FAULT_STORE = 2'd2;

  // Register byte offsets
  localparam logic [5:0] OFF_TCS  = 6'd0;
  localparam logic [5:0] OFF_TCT  = 6'd4;
  localparam logic [5:0] OFF_CSTR = 6'd8;
  localparam logic [5:0] OFF_RMSK = 6'd12;
  localparam logic [5:0] OFF_CNTL = 6'd16;
  localparam logic [5:0] OFF_CNTH = 6'd20;

  // Access rules: word size only, word aligned
  localparam logic [3:0] ACCESS_BYTES = 4'd4;
  localparam logic [5:0] ALIGN_MASK   = 6'd3;

  localparam int unsigned MASK_W = 8;

  typedef enum logic [2:0] {
    SEL_TCS,
    SEL_TCT,
    SEL_CSTR,
    SEL_RMSK,
    SEL_CNTL,
    SEL_CNTH,
    SEL_NONE
  } reg_sel_t;

  typedef struct packed {
    logic     tick;
    logic     rd;
    logic     wr;
    logic     bad;
    reg_sel_t sel;
  } dec_t;

endpackage

`default_nettype wire

### design/l64sc_in_stage.sv
// Input register: captures a word, decodes it and forms the tick increment.
`default_nettype none

module l64sc_in_stage #(
  parameter int unsigned COUNTS_PER_TICK = 80,
  parameter int unsigned INCR_W          = 39
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_action,
  input  wire logic [5:0]          in_byte_offset,
  input  wire logic [3:0]          in_access_size,
  input  wire logic [31:0]         in_write_data,
  input  wire logic [31:0]         in_elapsed_ticks,
  input  wire logic                ex_ready,
  output logic                     s1_valid,
  output l64sc_pkg::dec_t          s1_dec,
  output logic [31:0]              s1_data,
  output logic [INCR_W-1:0]        s1_incr
);
  import l64sc_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  dec_t              dec_r;
  dec_t              dec_nxt;
  logic [31:0]       data_r;
  logic [INCR_W-1:0] incr_r;
  logic [INCR_W-1:0] incr_nxt;
  logic              load;

  assign in_ready = !valid_r || ex_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (ex_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_comb begin
    dec_nxt      = '0;
    dec_nxt.sel  = SEL_NONE;
    case (in_action)
      ACT_TICK:  dec_nxt.tick = 1'b1;
      ACT_READ:  dec_nxt.rd   = 1'b1;
      ACT_WRITE: dec_nxt.wr   = 1'b1;
      default:   dec_nxt.tick = 1'b0;
    endcase
    dec_nxt.bad = (in_access_size != ACCESS_BYTES) ||
                  ((in_byte_offset & ALIGN_MASK) != '0);
    case (in_byte_offset)
      OFF_TCS:  dec_nxt.sel = SEL_TCS;
      OFF_TCT:  dec_nxt.sel = SEL_TCT;
      OFF_CSTR: dec_nxt.sel = SEL_CSTR;
      OFF_RMSK: dec_nxt.sel = SEL_RMSK;
      OFF_CNTL: dec_nxt.sel = SEL_CNTL;
      OFF_CNTH: dec_nxt.sel = SEL_CNTH;
      default:  dec_nxt.sel = SEL_NONE;
    endcase
  end

  // ticks times counts per tick, done here so the next stage only adds
  assign incr_nxt = INCR_W'(in_elapsed_ticks) * INCR_W'(COUNTS_PER_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec_r  <= dec_nxt;
      data_r <= in_write_data;
      incr_r <= incr_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_dec   = dec_r;
  assign s1_data  = data_r;
  assign s1_incr  = incr_r;

endmodule

`default_nettype wire

### design/l64sc_exec.sv
// Counter state, register file access and the result register.
`default_nettype none

module l64sc_exec #(
  parameter int unsigned INCR_W = 39
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                s1_valid,
  input  wire l64sc_pkg::dec_t     s1_dec,
  input  wire logic [31:0]         s1_data,
  input  wire logic [INCR_W-1:0]   s1_incr,
  output logic                     ex_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              out_read_data,
  output logic [1:0]               out_fault_code
);
  import l64sc_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [HALF_W-1:0]  latch_r, latch_nxt;
  logic [HALF_W-1:0]  hold_r, hold_nxt;
  logic               run_r, run_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;
  logic               oval_r, oval_nxt;
  logic [31:0]        rdata_r, rdata_nxt;
  logic [1:0]         fault_r, fault_nxt;
  logic               fire;

  assign ex_ready = !oval_r || out_ready;
  assign fire     = s1_valid && ex_ready;

  always_comb begin
    count_nxt = count_r;
    latch_nxt = latch_r;
    hold_nxt  = hold_r;
    run_nxt   = run_r;
    mask_nxt  = mask_r;
    rdata_nxt = '0;
    fault_nxt = FAULT_NONE;
    if (fire) begin
      if (s1_dec.tick && run_r) begin
        count_nxt = count_r + COUNT_W'(s1_incr);
      end
      if (s1_dec.rd) begin
        if (s1_dec.bad) begin
          fault_nxt = FAULT_LOAD;
        end else begin
          case (s1_dec.sel)
            SEL_CNTL: begin
              rdata_nxt = count_r[HALF_W-1:0];
              latch_nxt = count_r[COUNT_W-1:HALF_W];
            end
            SEL_CNTH: rdata_nxt = latch_r;
            SEL_CSTR: rdata_nxt = 32'(run_r);
            SEL_RMSK: rdata_nxt = 32'(mask_r);
            default:  rdata_nxt = '0;
          endcase
        end
      end
      if (s1_dec.wr) begin
        if (s1_dec.bad) begin
          fault_nxt = FAULT_STORE;
        end else begin
          case (s1_dec.sel)
            SEL_TCS: begin
              if (s1_data[0]) run_nxt = 1'b1;
            end
            SEL_TCT: begin
              if (s1_data[0]) run_nxt = 1'b0;
            end
            SEL_CNTL: begin
              if (!run_r) hold_nxt = s1_data;
            end
            SEL_CNTH: begin
              if (!run_r) count_nxt = {s1_data, hold_r};
            end
            SEL_RMSK: mask_nxt = s1_data[MASK_W-1:0];
            default:  mask_nxt = mask_r;
          endcase
        end
      end
    end
  end

  always_comb begin
    if (fire) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      latch_r <= '0;
      hold_r  <= '0;
      run_r   <= 1'b0;
      mask_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      latch_r <= latch_nxt;
      hold_r  <= hold_nxt;
      run_r   <= run_nxt;
      mask_r  <= mask_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rdata_r <= rdata_nxt;
      fault_r <= fault_nxt;
    end
  end

  assign out_valid      = oval_r;
  assign out_read_data  = rdata_r;
  assign out_fault_code = fault_r;

endmodule

`default_nettype wire

### design/latched_64bit_system_counter.sv
// Top level of the latched 64-bit system counter on a 32-bit register bus.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------------------
//  in_     | in        | in_valid / in_ready  | action, byte_offset, access_size, data, ticks
//  out_    | out       | out_valid / out_ready| read_data, fault_code
//
// One word per cycle while out_ready is high; words pass the input register, then
// the result register. The cycle is set by the 64-bit counter add in the execute
// stage; the tick multiply is done ahead of it, in front of the input register.
// Reset is synchronous, active low: counter, read latch, preset hold, run flag
// and mask all clear to zero, stopped. While out_ready is low the result holds,
// one more word waits in the input register, and then in_ready drops.
`default_nettype none

module latched_64bit_system_counter #(
  parameter int unsigned COUNTS_PER_TICK = 80
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [5:0]  in_byte_offset,
  input  wire logic [3:0]  in_access_size,
  input  wire logic [31:0] in_write_data,
  input  wire logic [31:0] in_elapsed_ticks,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_data,
  output logic [1:0]       out_fault_code
);
  import l64sc_pkg::*;

  // ticks (32 bits) times a constant up to COUNTS_PER_TICK
  localparam int unsigned INCR_W = 32 + $clog2(COUNTS_PER_TICK + 1);

  logic              ex_ready;
  logic              s1_valid;
  dec_t              s1_dec;
  logic [31:0]       s1_data;
  logic [INCR_W-1:0] s1_incr;

  // Stage 1: capture, decode, precompute increment
  l64sc_in_stage #(
    .COUNTS_PER_TICK(COUNTS_PER_TICK),
    .INCR_W         (INCR_W)
  ) u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_byte_offset  (in_byte_offset),
    .in_access_size  (in_access_size),
    .in_write_data   (in_write_data),
    .in_elapsed_ticks(in_elapsed_ticks),
    .ex_ready        (ex_ready),
    .s1_valid        (s1_valid),
    .s1_dec          (s1_dec),
    .s1_data         (s1_data),
    .s1_incr         (s1_incr)
  );

  // Stage 2: state update and result register
  l64sc_exec #(
    .INCR_W(INCR_W)
  ) u_exec (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1_valid      (s1_valid),
    .s1_dec        (s1_dec),
    .s1_data       (s1_data),
    .s1_incr       (s1_incr),
    .ex_ready      (ex_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_fault_code(out_fault_code)
  );

endmodule

`default_nettype wire

### design/l64sc_checker.sv
// Port-level checks for the latched 64-bit counter, bound to the top level.
`default_nettype none

module l64sc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_read_data,
  input wire logic [1:0]  out_fault_code
);
  import l64sc_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
                                $stable(out_fault_code))
    else $error("result word changed while stalled");

  // faulted access returns no data
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fault_code != FAULT_NONE) |-> out_read_data == '0)
    else $error("faulted access returned data");

  // unused fault code never shows
  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fault_code == FAULT_NONE) || (out_fault_code == FAULT_LOAD) ||
                  (out_fault_code == FAULT_STORE))
    else $error("undefined fault code");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind latched_64bit_system_counter l64sc_checker u_l64sc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_data (out_read_data),
  .out_fault_code(out_fault_code)
);

`default_nettype wire
